// ===== src/pmtu_pkg.sv =====
// Shared types, constants and the next-probe-size function for the path MTU probe search.
package pmtu_pkg;

    localparam logic [15:0] JUMP_MTU = 16'd1280;
    localparam logic [15:0] ONCE_MTU = 16'd1500;

    localparam logic [15:0] MAX_MTU_RST    = 16'd1500;
    localparam logic [10:0] PROBE_STEP_RST = 11'd80;
    localparam logic [7:0]  LOST_LIMIT_RST = 8'd3;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MTU    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_LIMIT = 2'd2;

    typedef enum logic [1:0] {
        REQ_START   = 2'd0,
        REQ_RESTART = 2'd1,
        REQ_ACK     = 2'd2,
        REQ_LOST    = 2'd3
    } t_req_type;

    typedef struct packed {
        logic [15:0] max_mtu;
        logic [10:0] probe_step;
        logic [7:0]  lost_limit;
    } t_cfg;

    typedef struct packed {
        t_req_type   req;
        logic [15:0] packet_size;
        logic [15:0] start_mtu;
        logic        min_validated;
    } t_event;

    typedef struct packed {
        logic        send_probe;
        logic [15:0] probe_size;
        logic [15:0] path_mtu;
        logic        complete;
        logic        ack_taken;
    } t_result;

    typedef struct packed {
        logic [15:0] size;
        logic        seen_1500;
    } t_next;

    // Next probe size from the current MTU; also returns the updated probed-1500 flag.
    function automatic t_next pmtu_next_size(input logic [15:0] cur, input logic seen,
                                             input t_cfg cfg);
        t_next       r;
        logic [16:0] sum;
        logic [15:0] m;
        r.seen_1500 = seen;
        sum = {1'b0, cur} + {6'd0, cfg.probe_step};
        if (cur < JUMP_MTU) begin
            r.size = (cfg.max_mtu < JUMP_MTU) ? cfg.max_mtu : JUMP_MTU;
        end else begin
            m = (sum > {1'b0, cfg.max_mtu}) ? cfg.max_mtu : sum[15:0];
            if (!seen && m >= ONCE_MTU) begin
                m = ONCE_MTU;
                r.seen_1500 = 1'b1;
            end
            r.size = m;
        end
        return r;
    endfunction

endpackage

// ===== src/path_mtu_probe_search.sv =====
// Top level: event input register, search logic, result output register.
// An event is held in the input register until the result register is free, then moves into it.
// Throughput: one event per cycle while the result is not stalled; the search state updates as
// an event moves from the input register into the result register.
// Reset: synchronous active-low; clears the search state (search complete, MTU zero),
// loads the configuration defaults and empties both registers.
module path_mtu_probe_search
    import pmtu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_req_type,
    input  logic [15:0]           i_packet_size,
    input  logic [15:0]           i_start_mtu,
    input  logic                  i_min_validated,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_send_probe,
    output logic [15:0]           o_probe_size_out,
    output logic [15:0]           o_path_mtu_out,
    output logic                  o_complete,
    output logic                  o_ack_taken,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_event  r_evt;
    t_result res;
    t_result r_res;
    logic    r_in_vld;
    logic    r_out_vld;
    logic    out_free;
    logic    proc;
    logic    in_take;

    assign o_cfg_ready = 1'b1;

    pmtu_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign out_free   = !r_out_vld || !i_out_stall;
    assign proc       = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (proc) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_evt.req           <= t_req_type'(i_req_type);
            r_evt.packet_size   <= i_packet_size;
            r_evt.start_mtu     <= i_start_mtu;
            r_evt.min_validated <= i_min_validated;
        end
    end

    pmtu_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (proc),
        .i_evt   (r_evt),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= proc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_res <= res;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_send_probe     = r_res.send_probe;
    assign o_probe_size_out = r_res.probe_size;
    assign o_path_mtu_out   = r_res.path_mtu;
    assign o_complete       = r_res.complete;
    assign o_ack_taken      = r_res.ack_taken;

`ifndef NO_ASSERTIONS
    // input side only stalls when an event is held back by a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld && i_out_stall))
        else $error("input stall without a blocked result");

    // a processed event always shows up as a result in the next cycle
    a_proc_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> r_out_vld)
        else $error("processed event lost");

    // an accepted ack that asks for no further probe must finish the search
    a_ack_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && o_ack_taken && !o_send_probe) |-> o_complete)
        else $error("ack without probe left search open");
`endif

endmodule

// ===== src/pmtu_cfg.sv =====
// Configuration registers of the path MTU probe search.
module pmtu_cfg
    import pmtu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_mtu    <= MAX_MTU_RST;
            r_cfg.probe_step <= PROBE_STEP_RST;
            r_cfg.lost_limit <= LOST_LIMIT_RST;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_MAX_MTU:    r_cfg.max_mtu    <= i_wr_data;
                CFG_PROBE_STEP: r_cfg.probe_step <= i_wr_data[10:0];
                CFG_LOST_LIMIT: r_cfg.lost_limit <= i_wr_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/pmtu_search.sv =====
// Search state registers and the per-event next-state and result logic.
module pmtu_search
    import pmtu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_fire,
    input  t_event  i_evt,
    output t_result o_res
);

    logic [15:0] r_cur, n_cur;
    logic [15:0] r_probe, n_probe;
    logic [7:0]  r_retry, n_retry;
    logic        r_seen, n_seen;
    logic        r_done, n_done;
    logic        r_minok, n_minok;

    logic [15:0] ent_cur;
    logic        ent_seen;
    logic        ent_minok;
    logic        do_entry;
    logic        send;
    logic        taken;
    logic        match;
    logic [8:0]  retry_inc;
    t_next       ns;

    assign match     = (i_evt.packet_size == r_probe);
    assign retry_inc = {1'b0, r_retry} + 9'd1;
    assign ns        = pmtu_next_size(ent_cur, ent_seen, i_cfg);

    // values the search entry starts from, per event kind
    always_comb begin
        ent_cur   = r_cur;
        ent_seen  = r_seen;
        ent_minok = r_minok;
        unique case (i_evt.req)
            REQ_START: begin
                ent_cur   = i_evt.start_mtu;
                ent_seen  = (i_evt.start_mtu >= ONCE_MTU);
                ent_minok = i_evt.min_validated;
            end
            REQ_RESTART: begin
                ent_minok = i_evt.min_validated;
            end
            REQ_ACK: begin
                ent_cur = r_probe;
            end
            REQ_LOST: ;
        endcase
    end

    always_comb begin
        n_cur     = r_cur;
        n_probe   = r_probe;
        n_retry   = r_retry;
        n_seen    = r_seen;
        n_done    = r_done;
        n_minok   = r_minok;
        send      = 1'b0;
        taken     = 1'b0;
        do_entry  = 1'b0;
        unique case (i_evt.req)
            REQ_START: begin
                do_entry  = 1'b1;
            end
            REQ_RESTART: begin
                do_entry  = 1'b1;
            end
            REQ_ACK: begin
                if (match) begin
                    taken   = 1'b1;
                    n_cur   = r_probe;
                    if (r_probe == i_cfg.max_mtu) begin
                        n_done = 1'b1;
                    end else begin
                        do_entry = 1'b1;
                    end
                end
            end
            REQ_LOST: begin
                if (match) begin
                    if (retry_inc >= {1'b0, i_cfg.lost_limit}) begin
                        n_done = 1'b1;
                    end else begin
                        n_retry = retry_inc[7:0];
                        send    = 1'b1;
                    end
                end
            end
        endcase

        if (do_entry) begin
            n_cur   = ent_cur;
            n_seen  = ent_seen;
            n_minok = ent_minok;
            n_retry = 8'd0;
            n_done  = 1'b0;
            if (ent_minok) begin
                n_probe = ns.size;
                n_seen  = ns.seen_1500;
            end else begin
                n_probe = ent_cur;
            end
            // validated minimum and nothing larger to try: done without a probe
            if (ent_minok && n_probe == ent_cur) begin
                n_done = 1'b1;
            end else begin
                send = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= 16'd0;
            r_probe <= 16'd0;
            r_retry <= 8'd0;
            r_seen  <= 1'b0;
            r_done  <= 1'b1;
            r_minok <= 1'b0;
        end else if (i_fire) begin
            r_cur   <= n_cur;
            r_probe <= n_probe;
            r_retry <= n_retry;
            r_seen  <= n_seen;
            r_done  <= n_done;
            r_minok <= n_minok;
        end
    end

    assign o_res.send_probe = send;
    assign o_res.probe_size = n_probe;
    assign o_res.path_mtu   = n_cur;
    assign o_res.complete   = n_done;
    assign o_res.ack_taken  = taken;

endmodule
